// ----- sv/mrrf_pkg.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Function codes, CRC-16/Modbus constants and the byte-wise CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrf_pkg;

  localparam logic [7:0]  FnReadHolding   = 8'h03;
  localparam logic [7:0]  FnWriteSingle   = 8'h06;
  localparam logic [7:0]  FnWriteMultiple = 8'h10;

  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPolyRefl = 16'hA001;

  localparam logic [0:0]  RegSlaveAddress = 1'b0;
  localparam logic [0:0]  RegCrcHighFirst = 1'b1;

  localparam logic        OpHeader = 1'b0;
  localparam logic        OpData   = 1'b1;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPolyRefl;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/modbus_rtu_request_framer_unit.sv -----
// The first frame byte of an item passes through the item stage and then the output register.
// Throughput: one frame byte per cycle while out_ready_i does not stall the stream;
// a header emits 6 to 9 bytes, a data word 1 or 3, a stray data word none.
// The single output byte register sets this rate.
// Reset: asynchronous, clears config, CRC to 0xFFFF, payload count to zero.
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns header and data words into a Modbus RTU request byte stream with a
// running CRC-16/Modbus appended at the end of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_framer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  func_code_i,
  input  wire logic [15:0] reg_address_i,
  input  wire logic [15:0] reg_count_i,
  input  wire logic [15:0] write_value_i,
  input  wire logic [7:0]  byte_count_i,
  input  wire logic [7:0]  data_byte_i,
  // output words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  frame_byte_o,
  output logic             frame_last_o
);

  // config registers
  logic [7:0] slave_addr_q;
  logic       crc_hi_first_q;

  // item stage
  logic        busy_q;
  logic        op_q;
  logic [7:0]  func_q;
  logic [15:0] addr_q;
  logic [15:0] count_q;
  logic [15:0] wval_q;
  logic [7:0]  bcount_q;
  logic [7:0]  data_q;
  logic [3:0]  idx_q, idx_d;

  // frame state
  logic [15:0] crc_q, crc_d;
  logic [7:0]  left_q, left_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic        cfg_wr;
  logic        out_free;
  logic        stray;
  logic        step;
  logic        final_byte;
  logic [3:0]  body_len;
  logic [3:0]  total;
  logic        crc_en;
  logic        is_crc;
  logic [7:0]  body_byte;
  logic [7:0]  crc_byte;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic [15:0] crc_base;
  logic        is_fn10;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    prdata = 32'h0;
    case (paddr[2])
      mrrf_pkg::RegSlaveAddress: prdata = {24'h0, slave_addr_q};
      mrrf_pkg::RegCrcHighFirst: prdata = {31'h0, crc_hi_first_q};
      default:                   prdata = 32'h0;
    endcase
  end

  assign is_fn10 = (func_q == mrrf_pkg::FnWriteMultiple);

  always_comb begin
    if (op_q == mrrf_pkg::OpData) begin
      body_len = 4'd1;
      crc_en   = (left_q == 8'd1) || (idx_q != 4'd0);
    end else begin
      case (func_q)
        mrrf_pkg::FnReadHolding:   body_len = 4'd6;
        mrrf_pkg::FnWriteSingle:   body_len = 4'd6;
        mrrf_pkg::FnWriteMultiple: body_len = 4'd7;
        default:                   body_len = 4'd4;
      endcase
      crc_en = !(is_fn10 && (bcount_q != 8'd0));
    end
  end

  assign total    = body_len + (crc_en ? 4'd2 : 4'd0);
  assign is_crc   = (idx_q >= body_len);
  assign out_free = !out_valid_q || out_ready_i;
  assign stray    = (op_q == mrrf_pkg::OpData) && (left_q == 8'd0) && (idx_q == 4'd0);
  assign step     = busy_q && (stray || out_free);
  assign final_byte = stray || (idx_q == total - 4'd1);

  assign in_ready_o = !busy_q || (step && final_byte);

  always_comb begin
    body_byte = data_q;
    if (op_q == mrrf_pkg::OpHeader) begin
      case (idx_q)
        4'd0:    body_byte = slave_addr_q;
        4'd1:    body_byte = func_q;
        4'd2:    body_byte = addr_q[15:8];
        4'd3:    body_byte = addr_q[7:0];
        4'd4:    body_byte = (func_q == mrrf_pkg::FnWriteSingle) ? wval_q[15:8] : count_q[15:8];
        4'd5:    body_byte = (func_q == mrrf_pkg::FnWriteSingle) ? wval_q[7:0] : count_q[7:0];
        4'd6:    body_byte = bcount_q;
        default: body_byte = 8'h00;
      endcase
    end
  end

  // first CRC byte when idx equals body length, second one after it
  always_comb begin
    if ((idx_q == body_len) ^ crc_hi_first_q) begin
      crc_byte = crc_q[7:0];
    end else begin
      crc_byte = crc_q[15:8];
    end
  end

  assign emit_byte = is_crc ? crc_byte : body_byte;
  assign emit_last = is_crc && (idx_q != body_len);
  assign crc_base  = ((op_q == mrrf_pkg::OpHeader) && (idx_q == 4'd0)) ? mrrf_pkg::CrcInit
                                                                      : crc_q;

  always_comb begin
    crc_d  = crc_q;
    left_d = left_q;
    idx_d  = idx_q;
    if (step && !stray) begin
      idx_d = final_byte ? 4'd0 : idx_q + 4'd1;
      if (!is_crc) begin
        crc_d = mrrf_pkg::crc_update(crc_base, body_byte);
      end
      if (idx_q == 4'd0) begin
        if (op_q == mrrf_pkg::OpHeader) begin
          left_d = is_fn10 ? bcount_q : 8'd0;
        end else begin
          left_d = left_q - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q   <= 8'h00;
      crc_hi_first_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        mrrf_pkg::RegSlaveAddress: slave_addr_q   <= pwdata[7:0];
        mrrf_pkg::RegCrcHighFirst: crc_hi_first_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 4'd0;
      crc_q       <= mrrf_pkg::CrcInit;
      left_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      left_q <= left_d;
      idx_q  <= idx_d;
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
      end else if (step && final_byte) begin
        busy_q <= 1'b0;
      end
      if (step && !stray) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= op_i;
      func_q   <= func_code_i;
      addr_q   <= reg_address_i;
      count_q  <= reg_count_i;
      wval_q   <= write_value_i;
      bcount_q <= byte_count_i;
      data_q   <= data_byte_i;
    end
    if (step && !stray) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_last_o = out_last_q;

  // assertions
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < total))
    else $error("byte index past end of word");

  a_last_closes_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (left_q == 8'd0))
    else $error("frame closed with payload outstanding");

  a_crc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !stray && is_crc) |=> $stable(crc_q))
    else $error("CRC changed while sending CRC bytes");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !step) |-> !in_ready_o)
    else $error("item stage overwritten");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modbus RTU request framer testbench
// Feeds header and data words through a valid/ready driver with random gaps,
// stalls the byte stream at random, and checks every frame byte and its last
// flag against a CRC-16/Modbus frame builder kept in step with the APB
// registers. Covers all function codes, empty and abandoned write-multiple
// frames, stray data words and both CRC byte orders.
// ----------------------------------------------------------------------------

module tb_top;

  typedef struct {
    logic        op;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] count;
    logic [15:0] wval;
    logic [7:0]  bcount;
    logic [7:0]  value;
  } req_word_t;

  typedef struct {
    logic [7:0] value;
    logic       is_last;
  } frame_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        op_i;
  logic [7:0]  func_code_i;
  logic [15:0] reg_address_i;
  logic [15:0] reg_count_i;
  logic [15:0] write_value_i;
  logic [7:0]  byte_count_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  frame_byte_o;
  logic        frame_last_o;

  req_word_t   request_q[$];
  frame_word_t frame_byte_q[$];

  // frame builder state
  logic [7:0]  cfg_slave;
  logic        cfg_crc_hi_first;
  logic [15:0] crc_acc;
  logic [7:0]  data_left;

  int          error_count;
  int          idle_pct;
  int          gap_left;
  int          stall_left;
  logic        word_taken;

  modbus_rtu_request_framer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .func_code_i   (func_code_i),
    .reg_address_i (reg_address_i),
    .reg_count_i   (reg_count_i),
    .write_value_i (write_value_i),
    .byte_count_i  (byte_count_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_byte_o  (frame_byte_o),
    .frame_last_o  (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  // bit-serial CRC-16/Modbus
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] value);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ value[k]) begin
        c = {1'b0, c[15:1]} ^ mrrf_pkg::CrcPolyRefl;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

  function automatic void emit_body(input logic [7:0] value);
    crc_acc = crc16_next(crc_acc, value);
    frame_byte_q.push_back('{value: value, is_last: 1'b0});
  endfunction

  function automatic void emit_crc();
    if (cfg_crc_hi_first) begin
      frame_byte_q.push_back('{value: crc_acc[15:8], is_last: 1'b0});
      frame_byte_q.push_back('{value: crc_acc[7:0], is_last: 1'b1});
    end else begin
      frame_byte_q.push_back('{value: crc_acc[7:0], is_last: 1'b0});
      frame_byte_q.push_back('{value: crc_acc[15:8], is_last: 1'b1});
    end
  endfunction

  function automatic void frame_request(input req_word_t w);
    if (w.op == mrrf_pkg::OpData) begin
      if (data_left != 8'd0) begin
        emit_body(w.value);
        data_left = data_left - 8'd1;
        if (data_left == 8'd0) emit_crc();
      end
    end else begin
      crc_acc   = mrrf_pkg::CrcInit;
      data_left = 8'd0;
      emit_body(cfg_slave);
      emit_body(w.func);
      emit_body(w.addr[15:8]);
      emit_body(w.addr[7:0]);
      case (w.func)
        mrrf_pkg::FnReadHolding: begin
          emit_body(w.count[15:8]);
          emit_body(w.count[7:0]);
        end
        mrrf_pkg::FnWriteSingle: begin
          emit_body(w.wval[15:8]);
          emit_body(w.wval[7:0]);
        end
        mrrf_pkg::FnWriteMultiple: begin
          emit_body(w.count[15:8]);
          emit_body(w.count[7:0]);
          emit_body(w.bcount);
          data_left = w.bcount;
        end
        default: ;
      endcase
      if (data_left == 8'd0) emit_crc();
    end
  endfunction

  // accept, predict and check at the rising edge
  always @(posedge clk_i) begin
    frame_word_t exp_w;
    req_word_t   w;
    word_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frame_byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected frame byte %02h last %0b",
                                    frame_byte_o, frame_last_o));
        end else begin
          exp_w = frame_byte_q.pop_front();
          if (frame_byte_o !== exp_w.value)
            report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                      frame_byte_o, exp_w.value));
          if (frame_last_o !== exp_w.is_last)
            report_mismatch($sformatf("frame_last %0b, expected %0b (byte %02h)",
                                      frame_last_o, exp_w.is_last, exp_w.value));
        end
      end
      if (in_valid_i && in_ready_o) begin
        w = '{op: op_i, func: func_code_i, addr: reg_address_i, count: reg_count_i,
              wval: write_value_i, bcount: byte_count_i, value: data_byte_i};
        frame_request(w);
      end
    end
  end

  // request word driver
  always @(negedge clk_i) begin
    req_word_t w;
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if (in_valid_i && idle_pct != 0 && $urandom_range(99) < idle_pct)
          gap_left = $urandom_range(1, 14);
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          w = request_q.pop_front();
          op_i          <= w.op;
          func_code_i   <= w.func;
          reg_address_i <= w.addr;
          reg_count_i   <= w.count;
          write_value_i <= w.wval;
          byte_count_i  <= w.bcount;
          data_byte_i   <= w.value;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // byte stream backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct / 4)
        stall_left = $urandom_range(1, 14);
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == mrrf_pkg::RegSlaveAddress) cfg_slave = value[7:0];
    else if (idx == mrrf_pkg::RegCrcHighFirst) cfg_crc_hi_first = value[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic req_word_t rand_word();
    req_word_t w;
    w.op     = 1'($urandom_range(1));
    w.func   = 8'($urandom);
    w.addr   = 16'($urandom);
    w.count  = 16'($urandom);
    w.wval   = 16'($urandom);
    w.bcount = 8'($urandom);
    w.value  = 8'($urandom);
    return w;
  endfunction

  task automatic push_header(input logic [7:0] func, input logic [15:0] addr,
                             input logic [15:0] count, input logic [15:0] wval,
                             input logic [7:0] bcount);
    req_word_t w;
    w = rand_word();
    w.op     = mrrf_pkg::OpHeader;
    w.func   = func;
    w.addr   = addr;
    w.count  = count;
    w.wval   = wval;
    w.bcount = bcount;
    request_q.push_back(w);
  endtask

  task automatic push_data(input logic [7:0] value);
    req_word_t w;
    w = rand_word();
    w.op    = mrrf_pkg::OpData;
    w.value = value;
    request_q.push_back(w);
  endtask

  // mostly complete frames with random content, some stray and cut-short ones
  task automatic push_random_frames(input int n_words);
    int          n;
    int          kind;
    int          n_data;
    logic [7:0]  func;
    logic [7:0]  bcount;
    n = 0;
    while (n < n_words) begin
      if ($urandom_range(99) < 8) begin
        push_data(8'($urandom));
      end else begin
        kind = $urandom_range(3);
        case (kind)
          0: func = mrrf_pkg::FnReadHolding;
          1: func = mrrf_pkg::FnWriteSingle;
          2: func = mrrf_pkg::FnWriteMultiple;
          default: func = 8'($urandom);
        endcase
        bcount = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
        push_header(func, 16'($urandom), 16'($urandom), 16'($urandom), bcount);
        n++;
        if (func == mrrf_pkg::FnWriteMultiple) begin
          n_data = int'(bcount);
          if (n_data > 8 || $urandom_range(9) == 0) n_data = $urandom_range(0, n_data > 8 ? 8 : n_data);
          for (int k = 0; k < n_data; k++) push_data(8'($urandom));
          n += n_data;
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid_i || frame_byte_q.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    error_count      = 0;
    idle_pct         = 0;
    gap_left         = 0;
    stall_left       = 0;
    word_taken       = 1'b0;
    cfg_slave        = 8'h00;
    cfg_crc_hi_first = 1'b0;
    crc_acc          = mrrf_pkg::CrcInit;
    data_left        = 8'd0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    op_i             = 1'b0;
    func_code_i      = '0;
    reg_address_i    = '0;
    reg_count_i      = '0;
    write_value_i    = '0;
    byte_count_i     = '0;
    data_byte_i      = '0;
    out_ready_i      = 1'b0;
    rst_ni           = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words, reset register values
    idle_pct = 30;
    push_header(mrrf_pkg::FnReadHolding, 16'h0000, 16'hFFFF, 16'($urandom), 8'($urandom));
    push_header(mrrf_pkg::FnReadHolding, 16'hFFFF, 16'h0000, 16'($urandom), 8'($urandom));
    push_header(mrrf_pkg::FnWriteSingle, 16'h1234, 16'($urandom), 16'hFFFF, 8'($urandom));
    push_header(mrrf_pkg::FnWriteSingle, 16'h8001, 16'($urandom), 16'h0000, 8'($urandom));
    push_header(mrrf_pkg::FnWriteMultiple, 16'h0100, 16'h0001, 16'($urandom), 8'd2);
    push_data(8'h00);
    push_data(8'hFF);
    push_header(mrrf_pkg::FnWriteMultiple, 16'h0010, 16'h0000, 16'($urandom), 8'd0);
    push_data(8'h5A);
    push_header(8'h00, 16'hA5A5, 16'($urandom), 16'($urandom), 8'($urandom));
    push_header(8'hFF, 16'h5A5A, 16'($urandom), 16'($urandom), 8'($urandom));
    push_header(mrrf_pkg::FnWriteMultiple, 16'hFFFF, 16'hFFFF, 16'($urandom), 8'd255);
    push_data(8'h81);
    push_data(8'h7E);
    push_header(mrrf_pkg::FnWriteMultiple, 16'h0002, 16'h0002, 16'($urandom), 8'd3);
    push_data(8'hC3);
    push_header(mrrf_pkg::FnWriteSingle, 16'h0003, 16'($urandom), 16'h55AA, 8'($urandom));
    push_data(8'h3C);
    push_header(mrrf_pkg::FnWriteMultiple, 16'h0004, 16'h0001, 16'($urandom), 8'd1);
    push_data(8'hA5);
    wait_idle();

    write_reg(mrrf_pkg::RegSlaveAddress, 32'h0000_00FF);
    write_reg(mrrf_pkg::RegCrcHighFirst, 32'h0000_0001);
    idle_pct = 40;
    push_random_frames(60);
    wait_idle();

    write_reg(mrrf_pkg::RegSlaveAddress, 32'h0000_0000);
    write_reg(mrrf_pkg::RegCrcHighFirst, 32'h0000_0001);
    idle_pct = 0;
    push_random_frames(60);
    wait_idle();

    write_reg(mrrf_pkg::RegSlaveAddress, $urandom);
    write_reg(mrrf_pkg::RegCrcHighFirst, 32'h0000_0000);
    idle_pct = $urandom_range(10, 60);
    push_random_frames(60);
    wait_idle();

    write_reg(mrrf_pkg::RegSlaveAddress, $urandom);
    write_reg(mrrf_pkg::RegCrcHighFirst, $urandom);
    idle_pct = 0;
    push_random_frames(60);
    wait_idle();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mrrf_pkg.sv
sv/modbus_rtu_request_framer_unit.sv
tb/sv/tb_top.sv
